FILE: sv/cdsl_pkg.sv
// Shared types, constants and register codes for the code diff site locator.
package cdsl_pkg;

    // Capture window and queue sizing
    localparam int CAPTURE_BYTES = 16;
    localparam int FILL_W        = $clog2(CAPTURE_BYTES) + 1;
    localparam int SITES_W       = 5;
    localparam int MAX_SITES_DEF = 8;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = QPTR_W + 1;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;
    localparam logic [1:0] REG_SEGMENT_BASE   = 2'd0;
    localparam logic [1:0] REG_SEGMENT_LENGTH = 2'd1;
    localparam logic [1:0] REG_SITE_GAP       = 2'd2;
    localparam logic [7:0] SITE_GAP_RESET     = 8'd16;

    // Record kinds
    localparam logic REC_SITE    = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    // Jump stub decode: LDR Xt, #8 followed by BR Xt
    localparam logic [31:0] LDR_MASK  = 32'hFF00_0000;
    localparam logic [31:0] LDR_MATCH = 32'h5800_0000;
    localparam logic [18:0] LDR_IMM8  = 19'd2;
    localparam logic [31:0] BR_MASK   = 32'hFFFF_FC1F;
    localparam logic [31:0] BR_MATCH  = 32'hD61F_0000;

    typedef struct packed {
        logic [7:0] live_byte;
        logic [7:0] ref_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic        record_kind;
        logic [31:0] site_offset;
        logic [31:0] run_length;
        logic [63:0] live_low;
        logic [63:0] live_high;
        logic [63:0] ref_low;
        logic [63:0] ref_high;
        logic        jump_stub;
        logic [63:0] stub_target;
        logic        target_outside;
        logic [31:0] differing_bytes;
        logic [31:0] total_sites;
    } out_t;

    typedef struct packed {
        logic [63:0] segment_base;
        logic [31:0] segment_length;
        logic [7:0]  site_gap;
    } cfg_t;

    // Queue entry: a site record or a summary; word_a/word_b carry offset and
    // length for a site, differing count and site count for a summary.
    typedef struct packed {
        logic         kind;
        logic [31:0]  word_a;
        logic [31:0]  word_b;
        logic [127:0] live;
        logic [127:0] refc;
        logic         full;
    } evt_t;

    typedef struct packed {
        logic push0;
        logic push1;
    } push_t;

    typedef struct packed {
        logic room;
        logic not_empty;
    } qstat_t;

endpackage

FILE: sv/cdsl_regs.sv
// Configuration register file behind the APB-style port.
module cdsl_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cdsl_pkg::PADDR_W-1:0]   paddr,
    input  logic [cdsl_pkg::PDATA_W-1:0]   pwdata,
    output logic [cdsl_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output cdsl_pkg::cfg_t                 cfg
);
    import cdsl_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];
    assign cfg     = cfg_reg;

    // Write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.segment_base   <= '0;
            cfg_reg.segment_length <= '0;
            cfg_reg.site_gap       <= SITE_GAP_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SEGMENT_BASE:   cfg_reg.segment_base   <= pwdata;
                REG_SEGMENT_LENGTH: cfg_reg.segment_length <= pwdata[31:0];
                REG_SITE_GAP:       cfg_reg.site_gap       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_SEGMENT_BASE:   prdata = cfg_reg.segment_base;
            REG_SEGMENT_LENGTH: prdata = {32'd0, cfg_reg.segment_length};
            REG_SITE_GAP:       prdata = {56'd0, cfg_reg.site_gap};
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: sv/cdsl_front.sv
// Front end: compares byte pairs, tracks runs and capture, emits site and summary events.
module cdsl_front #(
    parameter int MAX_SITES = cdsl_pkg::MAX_SITES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  cdsl_pkg::in_t    in_beat,
    input  logic [7:0]       site_gap,
    output cdsl_pkg::push_t  push,
    output cdsl_pkg::evt_t   evt0,
    output cdsl_pkg::evt_t   evt1
);
    import cdsl_pkg::*;

    logic [31:0]       position_reg;
    logic              in_run_reg;
    logic [31:0]       run_start_reg;
    logic [31:0]       run_end_reg;
    logic [31:0]       diff_count_reg;
    logic [31:0]       site_total_reg;
    logic [SITES_W-1:0] sites_rec_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [7:0]        cap_live_reg [CAPTURE_BYTES];
    logic [7:0]        cap_refc_reg [CAPTURE_BYTES];

    logic              diff, start_new, in_run_a, do_cap;
    logic [FILL_W-1:0] fill_a, fill_next;
    logic [31:0]       run_start_next, run_end_next;
    logic [31:0]       diff_count_next, site_total_next;
    logic              gap_close, last_close, site_close, site_rec;
    logic [7:0]        cap_live_next [CAPTURE_BYTES];
    logic [7:0]        cap_refc_next [CAPTURE_BYTES];
    logic [127:0]      live_pk, refc_pk;
    evt_t              site_evt, sum_evt;

    // Classify the byte pair and work out the run update
    always_comb begin
        diff      = in_beat.live_byte != in_beat.ref_byte;
        start_new = diff && !in_run_reg;
        in_run_a  = diff || in_run_reg;
        fill_a    = start_new ? '0 : fill_reg;
        do_cap    = in_run_a && (fill_a < FILL_W'(CAPTURE_BYTES));
        fill_next = fill_a + FILL_W'(do_cap);

        run_start_next = start_new ? position_reg : run_start_reg;
        run_end_next   = diff ? position_reg + 32'd1 : run_end_reg;

        for (int k = 0; k < CAPTURE_BYTES; k++) begin
            if (do_cap && (fill_a == FILL_W'(k))) begin
                cap_live_next[k] = in_beat.live_byte;
                cap_refc_next[k] = in_beat.ref_byte;
            end else if (start_new) begin
                cap_live_next[k] = 8'd0;
                cap_refc_next[k] = 8'd0;
            end else begin
                cap_live_next[k] = cap_live_reg[k];
                cap_refc_next[k] = cap_refc_reg[k];
            end
            live_pk[8*k +: 8] = cap_live_next[k];
            refc_pk[8*k +: 8] = cap_refc_next[k];
        end

        gap_close  = !diff && in_run_reg && (fill_next >= FILL_W'(CAPTURE_BYTES)) &&
                     ((position_reg - run_end_reg) >= {24'd0, site_gap});
        last_close = in_beat.final_byte && in_run_a && !gap_close;
        site_close = gap_close || last_close;
        site_rec   = site_close && (sites_rec_reg < SITES_W'(MAX_SITES));

        diff_count_next = diff_count_reg + 32'(diff);
        site_total_next = site_total_reg + 32'(site_close);

        site_evt.kind   = REC_SITE;
        site_evt.word_a = run_start_next;
        site_evt.word_b = run_end_next - run_start_next;
        site_evt.live   = live_pk;
        site_evt.refc   = refc_pk;
        site_evt.full   = fill_next >= FILL_W'(CAPTURE_BYTES);

        sum_evt        = '0;
        sum_evt.kind   = REC_SUMMARY;
        sum_evt.word_a = diff_count_next;
        sum_evt.word_b = site_total_next;
    end

    // Steer events onto the two queue write slots
    always_comb begin
        push.push0 = accept && (site_rec || in_beat.final_byte);
        push.push1 = accept && site_rec && in_beat.final_byte;
        evt0       = site_rec ? site_evt : sum_evt;
        evt1       = sum_evt;
    end

    // Advance stream state; drop back to reset after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            in_run_reg     <= 1'b0;
            run_start_reg  <= '0;
            run_end_reg    <= '0;
            diff_count_reg <= '0;
            site_total_reg <= '0;
            sites_rec_reg  <= '0;
            fill_reg       <= '0;
        end else if (accept) begin
            if (in_beat.final_byte) begin
                position_reg   <= '0;
                in_run_reg     <= 1'b0;
                run_start_reg  <= '0;
                run_end_reg    <= '0;
                diff_count_reg <= '0;
                site_total_reg <= '0;
                sites_rec_reg  <= '0;
                fill_reg       <= '0;
            end else begin
                position_reg   <= position_reg + 32'd1;
                in_run_reg     <= in_run_a && !site_close;
                run_start_reg  <= run_start_next;
                run_end_reg    <= run_end_next;
                diff_count_reg <= diff_count_next;
                site_total_reg <= site_total_next;
                sites_rec_reg  <= sites_rec_reg + SITES_W'(site_rec);
                fill_reg       <= fill_next;
            end
        end
    end

    // Capture window; cleared at the start of each run
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < CAPTURE_BYTES; k++) begin
                cap_live_reg[k] <= cap_live_next[k];
                cap_refc_reg[k] <= cap_refc_next[k];
            end
        end
    end

endmodule

FILE: sv/cdsl_queue.sv
// Event queue between front and back: up to two writes and one read per cycle.
module cdsl_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  cdsl_pkg::push_t  push,
    input  cdsl_pkg::evt_t   evt0,
    input  cdsl_pkg::evt_t   evt1,
    input  logic             pop,
    output cdsl_pkg::evt_t   head,
    output cdsl_pkg::qstat_t stat
);
    import cdsl_pkg::*;

    evt_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_inc;

    assign wr_ptr_inc     = wr_ptr_reg + QPTR_W'(1);
    assign head           = q_mem[rd_ptr_reg];
    assign stat.not_empty = count_reg != '0;
    assign stat.room      = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign count_next     = count_reg + QCNT_W'(push.push0) + QCNT_W'(push.push1)
                            - QCNT_W'(pop);

    // Store pushed events
    always_ff @(posedge aclk) begin
        if (push.push0) begin
            q_mem[wr_ptr_reg] <= evt0;
        end
        if (push.push1) begin
            q_mem[wr_ptr_inc] <= evt1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push.push0) + QPTR_W'(push.push1);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/cdsl_back.sv
// Back end: stub decode, segment range check and the output register.
module cdsl_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  cdsl_pkg::evt_t   head,
    input  logic             head_valid,
    input  logic [63:0]      segment_base,
    input  logic [31:0]      segment_length,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output cdsl_pkg::out_t   m_data
);
    import cdsl_pkg::*;

    logic        m_valid_reg;
    out_t        out_reg, out_next;
    logic        load;
    logic [31:0] w0, w1;
    logic [63:0] target;
    logic        stub;
    logic [64:0] offs;
    logic        outside;

    assign load    = !m_valid_reg || m_ready;
    assign pop     = load && head_valid;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Decode the stub and check its target against the segment
    always_comb begin
        w0     = head.live[31:0];
        w1     = head.live[63:32];
        target = head.live[127:64];
        stub   = (head.kind == REC_SITE) && head.full &&
                 ((w0 & LDR_MASK) == LDR_MATCH) && (w0[23:5] == LDR_IMM8) &&
                 ((w1 & BR_MASK) == BR_MATCH) && (w1[9:5] == w0[4:0]);
        offs    = {1'b0, target} - {1'b0, segment_base};
        outside = offs[64] || (offs[63:32] != 32'd0) || (offs[31:0] >= segment_length);

        out_next = '0;
        out_next.record_kind = head.kind;
        if (head.kind == REC_SITE) begin
            out_next.site_offset    = head.word_a;
            out_next.run_length     = head.word_b;
            out_next.live_low       = head.live[63:0];
            out_next.live_high      = head.live[127:64];
            out_next.ref_low        = head.refc[63:0];
            out_next.ref_high       = head.refc[127:64];
            out_next.jump_stub      = stub;
            out_next.stub_target    = stub ? target : 64'd0;
            out_next.target_outside = stub && outside;
        end else begin
            out_next.differing_bytes = head.word_a;
            out_next.total_sites     = head.word_b;
        end
    end

    // Hold the result until the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: sv/code_diff_site_locator.sv
// Top level of the code diff site locator.
// Takes one live/reference byte pair per cycle for as long as the event queue has room for
// two entries; compare, counting and the 16-byte capture all finish in that cycle in the
// front end. Site records and the end summary pass through a four-entry queue to the back
// end, which decodes the jump stub, checks its target against the segment and drains one
// result per cycle into the output register while the sink keeps up; a final byte closing a
// site, the only byte with two results, does not stall input by itself. Registers sit at byte
// addresses 0, 8 and 16 and must be written only while the block is idle, which the block does not enforce.
module code_diff_site_locator #(
    parameter int MAX_SITES = cdsl_pkg::MAX_SITES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  cdsl_pkg::in_t                s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output cdsl_pkg::out_t               m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cdsl_pkg::PADDR_W-1:0] paddr,
    input  logic [cdsl_pkg::PDATA_W-1:0] pwdata,
    output logic [cdsl_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import cdsl_pkg::*;

    cfg_t   cfg;
    push_t  push;
    evt_t   evt0, evt1, head;
    qstat_t stat;
    logic   accept, pop;

    assign s_ready = stat.room;
    assign accept  = s_valid && stat.room;

    cdsl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cdsl_front #(
        .MAX_SITES (MAX_SITES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_beat  (s_data),
        .site_gap (cfg.site_gap),
        .push     (push),
        .evt0     (evt0),
        .evt1     (evt1)
    );

    cdsl_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .evt0    (evt0),
        .evt1    (evt1),
        .pop     (pop),
        .head    (head),
        .stat    (stat)
    );

    cdsl_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .head_valid     (stat.not_empty),
        .segment_base   (cfg.segment_base),
        .segment_length (cfg.segment_length),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

FILE: tb/sv/tb_code_diff_site_locator.sv
// Self-checking code diff site locator testbench: directed rows, a held-off burst, random streams.
module tb_code_diff_site_locator;
    import cdsl_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int IDLE_PERCENT    = 22;
    localparam int PHASE_BEATS     = 35;
    localparam int PHASE_COUNT     = 6;
    localparam int PRESSURE_BEATS  = 12;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // One directed row; a row that ends a stream may carry the summary counts typed in
    typedef struct packed {
        logic [7:0] live_byte;
        logic [7:0] ref_byte;
        logic       final_byte;
        logic       has_summary;
        logic [7:0] diffs;
        logic [7:0] sites;
    } row_t;

    localparam row_t DIRECTED_ROWS [22] = '{
        // equal pair alone, then a lone differing pair, each ending its stream
        '{8'h00, 8'h00, 1'b1, 1'b1, 8'd0, 8'd0},
        '{8'hFF, 8'h00, 1'b1, 1'b1, 8'd1, 8'd1},
        // short run closed by the stream end
        '{8'h00, 8'hFF, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hFF, 8'hFF, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h80, 8'h7F, 1'b1, 1'b1, 8'd2, 8'd1},
        // full jump stub through x17, target outside an empty segment
        '{8'h51, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h58, 8'h58, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h20, 8'h20, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h02, 8'h02, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h1F, 8'h1F, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hD6, 8'hD6, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hEF, 8'hEF, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hCD, 8'hCD, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hAB, 8'hAB, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h89, 8'h89, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h67, 8'h67, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h45, 8'h45, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h23, 8'h23, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h01, 8'h01, 1'b1, 1'b1, 8'd1, 8'd1},
        // a fresh stream straight after a final byte
        '{8'h01, 8'h01, 1'b1, 1'b1, 8'd0, 8'd0}
    };

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_t                s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_t               m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Side information travelling with the current input beat
    logic       beat_has_summary = 1'b0;
    logic [7:0] beat_diffs       = '0;
    logic [7:0] beat_sites       = '0;

    // Stimulus control
    logic steady      = 1'b0;
    int   hold_left   = 0;
    int   beats_sent  = 0;
    int   error_count = 0;
    int   cycle_count = 0;

    // Predicted register contents
    logic [63:0] seg_base_cfg = '0;
    logic [31:0] seg_len_cfg  = '0;
    logic [7:0]  gap_cfg      = SITE_GAP_RESET;

    // Predicted stream state
    logic [31:0]  byte_pos     = '0;
    logic         run_open     = 1'b0;
    logic [31:0]  run_first    = '0;
    logic [31:0]  run_past     = '0;
    logic [31:0]  diff_total   = '0;
    logic [31:0]  site_total   = '0;
    int           sites_logged = 0;
    logic [127:0] window_live  = '0;
    logic [127:0] window_ref   = '0;
    int           window_fill  = 0;

    out_t pending_records[$];
    out_t due_rec;
    out_t typed_summary;

    code_diff_site_locator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // Close the open site; queue its record while record slots remain
    function automatic void close_site_record();
        out_t        rec;
        logic [31:0] ldr_word;
        logic [31:0] br_word;
        logic [63:0] target;
        run_open = 1'b0;
        site_total++;
        if (sites_logged >= MAX_SITES_DEF) return;
        sites_logged++;
        ldr_word = window_live[31:0];
        br_word  = window_live[63:32];
        target   = window_live[127:64];
        rec = '0;
        rec.record_kind = REC_SITE;
        rec.site_offset = run_first;
        rec.run_length  = run_past - run_first;
        rec.live_low    = window_live[63:0];
        rec.live_high   = window_live[127:64];
        rec.ref_low     = window_ref[63:0];
        rec.ref_high    = window_ref[127:64];
        // Stub check only on a full window: LDR Xt, #8 then BR of the same Xt
        if (window_fill >= CAPTURE_BYTES && (ldr_word & LDR_MASK) == LDR_MATCH &&
            ldr_word[23:5] == LDR_IMM8 && (br_word & BR_MASK) == BR_MATCH &&
            br_word[9:5] == ldr_word[4:0]) begin
            rec.jump_stub      = 1'b1;
            rec.stub_target    = target;
            rec.target_outside = target < seg_base_cfg ||
                                 (target - seg_base_cfg) >= {32'd0, seg_len_cfg};
        end
        pending_records = {pending_records, rec};
    endfunction

    // Advance the stream by one byte pair and queue the records it closes
    function automatic void locate_sites(input in_t beat);
        logic        differs;
        logic [31:0] since_diff;
        out_t        summary;
        differs = beat.live_byte != beat.ref_byte;
        if (differs) begin
            diff_total++;
            if (!run_open) begin
                run_open    = 1'b1;
                run_first   = byte_pos;
                window_fill = 0;
                window_live = '0;
                window_ref  = '0;
            end
            run_past = byte_pos + 32'd1;
        end
        if (run_open && window_fill < CAPTURE_BYTES) begin
            window_live[8*window_fill +: 8] = beat.live_byte;
            window_ref[8*window_fill +: 8]  = beat.ref_byte;
            window_fill++;
        end
        since_diff = byte_pos - run_past;
        if (!differs && run_open && window_fill >= CAPTURE_BYTES &&
            since_diff >= {24'd0, gap_cfg}) begin
            close_site_record();
        end
        byte_pos++;
        // Final byte: close any open site, add the summary, restart the stream
        if (beat.final_byte) begin
            if (run_open) close_site_record();
            summary = '0;
            summary.record_kind     = REC_SUMMARY;
            summary.differing_bytes = diff_total;
            summary.total_sites     = site_total;
            pending_records = {pending_records, summary};
            byte_pos     = '0;
            run_open     = 1'b0;
            run_first    = '0;
            run_past     = '0;
            diff_total   = '0;
            site_total   = '0;
            sites_logged = 0;
            window_live  = '0;
            window_ref   = '0;
            window_fill  = 0;
        end
    endfunction

    // Predict on accepted input beats, check accepted result beats
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            locate_sites(s_data);
            if (beat_has_summary) begin
                typed_summary = '0;
                typed_summary.record_kind     = REC_SUMMARY;
                typed_summary.differing_bytes = {24'd0, beat_diffs};
                typed_summary.total_sites     = {24'd0, beat_sites};
                pending_records[pending_records.size()-1] = typed_summary;
            end
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_records.size() == 0) begin
                report_mismatch("result beat with no record outstanding");
            end else begin
                due_rec = pending_records.pop_front();
                check_field("record_kind", 64'(m_data.record_kind),
                            64'(due_rec.record_kind));
                check_field("site_offset", 64'(m_data.site_offset),
                            64'(due_rec.site_offset));
                check_field("run_length", 64'(m_data.run_length),
                            64'(due_rec.run_length));
                check_field("live_low", m_data.live_low, due_rec.live_low);
                check_field("live_high", m_data.live_high, due_rec.live_high);
                check_field("ref_low", m_data.ref_low, due_rec.ref_low);
                check_field("ref_high", m_data.ref_high, due_rec.ref_high);
                check_field("jump_stub", 64'(m_data.jump_stub), 64'(due_rec.jump_stub));
                check_field("stub_target", m_data.stub_target, due_rec.stub_target);
                check_field("target_outside", 64'(m_data.target_outside),
                            64'(due_rec.target_outside));
                check_field("differing_bytes", 64'(m_data.differing_bytes),
                            64'(due_rec.differing_bytes));
                check_field("total_sites", 64'(m_data.total_sites),
                            64'(due_rec.total_sites));
            end
        end
    end

    // Result side: long hold-off when asked, otherwise random back-pressure unless steady
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offer one beat after random idle cycles (none when steady) and hold it until accepted
    task automatic send_beat(input in_t beat, input logic has_sum = 1'b0,
                             input logic [7:0] diffs = '0, input logic [7:0] sites = '0);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_data           <= beat;
        beat_has_summary <= has_sum;
        beat_diffs       <= diffs;
        beat_sites       <= sites;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        beats_sent++;
    endtask

    // Drop valid and wait for every outstanding record plus the pipeline tail
    task automatic drain_records();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Setup and access cycle, then mirror the write into the predictor
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        case (idx)
            REG_SEGMENT_BASE:   seg_base_cfg = value;
            REG_SEGMENT_LENGTH: seg_len_cfg  = value[31:0];
            REG_SITE_GAP:       gap_cfg      = value[7:0];
            default: ;
        endcase
    endtask

    // Sixteen live bytes of a jump stub, optionally with one instruction bit flipped
    function automatic logic [127:0] stub_bytes(input logic [63:0] target, input logic broken);
        logic [4:0]   reg_no;
        logic [31:0]  ldr_word;
        logic [31:0]  br_word;
        logic [127:0] stub;
        reg_no   = 5'($urandom_range(31));
        ldr_word = LDR_MATCH | {8'h00, LDR_IMM8, reg_no};
        br_word  = BR_MATCH | {22'd0, reg_no, 5'd0};
        stub     = {target, br_word, ldr_word};
        if (broken) stub[$urandom_range(63)] ^= 1'b1;
        return stub;
    endfunction

    // Random streams of equal stretches, differing bursts, stubs and noise
    task automatic run_phase(input int beat_budget);
        in_t          stream[$];
        in_t          beat;
        logic [127:0] stub_live;
        logic [63:0]  target;
        int           stream_len;
        int           chunk;
        int           stretch;
        int           first_beat;
        first_beat = beats_sent;
        while (beats_sent - first_beat < beat_budget) begin
            stream.delete();
            // Gap of zero: open with one long stream so sites run past the record limit
            if (gap_cfg == 8'd0 && beats_sent == first_beat) begin
                stream_len = $urandom_range(160, 200);
            end else begin
                stream_len = $urandom_range(1, 50);
            end
            beat.final_byte = 1'b0;
            while (stream.size() < stream_len) begin
                chunk = $urandom_range(99);
                if (chunk < 10 || (stream.size() == 0 && chunk < 40)) begin
                    // Jump stub whose target mostly sits on or near the segment edges
                    case ($urandom_range(5))
                        0:       target = seg_base_cfg - 64'd1;
                        1:       target = seg_base_cfg + {32'd0, seg_len_cfg};
                        2:       target = seg_base_cfg + {32'd0, seg_len_cfg} - 64'd1;
                        3:       target = seg_base_cfg;
                        4:       target = seg_base_cfg +
                                          ($urandom % ((seg_len_cfg == 0) ? 1 : seg_len_cfg));
                        default: target = {$urandom, $urandom};
                    endcase
                    stub_live = stub_bytes(target, $urandom_range(3) == 0);
                    for (int k = 0; k < CAPTURE_BYTES; k++) begin
                        beat.live_byte = stub_live[8*k +: 8];
                        beat.ref_byte  = beat.live_byte;
                        if (k == 0 || $urandom_range(3) == 0) begin
                            beat.ref_byte = beat.live_byte ^ 8'($urandom_range(1, 255));
                        end
                        stream = {stream, beat};
                    end
                end else if (chunk < 55) begin
                    // Equal stretch, now and then long enough to close a site
                    stretch = ($urandom_range(7) == 0) ? int'(gap_cfg) + $urandom_range(0, 3)
                                                       : $urandom_range(1, 12);
                    repeat (stretch) begin
                        beat.live_byte = 8'($urandom);
                        beat.ref_byte  = beat.live_byte;
                        stream = {stream, beat};
                    end
                end else if (chunk < 88) begin
                    repeat ($urandom_range(1, 4)) begin
                        beat.live_byte = 8'($urandom);
                        beat.ref_byte  = beat.live_byte ^ 8'($urandom_range(1, 255));
                        stream = {stream, beat};
                    end
                end else begin
                    repeat ($urandom_range(1, 8)) begin
                        beat.live_byte = 8'($urandom);
                        beat.ref_byte  = $urandom_range(1) ? beat.live_byte : 8'($urandom);
                        stream = {stream, beat};
                    end
                end
            end
            stream[stream.size()-1].final_byte = 1'b1;
            foreach (stream[i]) send_beat(stream[i]);
        end
    endtask

    initial begin
        in_t beat;
        row_t row;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows under the reset register values
        foreach (DIRECTED_ROWS[i]) begin
            row = DIRECTED_ROWS[i];
            beat.live_byte  = row.live_byte;
            beat.ref_byte   = row.ref_byte;
            beat.final_byte = row.final_byte;
            send_beat(beat, row.has_summary, row.diffs, row.sites);
        end
        drain_records();

        // Hold the result side off while two-record beats keep arriving
        @(posedge aclk);
        hold_left = HOLD_OFF_CYCLES;
        @(negedge aclk);
        repeat (PRESSURE_BEATS) begin
            beat.live_byte  = 8'($urandom);
            beat.ref_byte   = beat.live_byte ^ 8'($urandom_range(1, 255));
            beat.final_byte = 1'b1;
            send_beat(beat);
        end
        drain_records();

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin
                    write_reg(REG_SEGMENT_BASE, 64'h0000_0000_0040_0000);
                    write_reg(REG_SEGMENT_LENGTH, 64'h0000_0000_0001_0000);
                    write_reg(REG_SITE_GAP, 64'd16);
                end
                1: begin
                    write_reg(REG_SEGMENT_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
                    write_reg(REG_SEGMENT_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
                    write_reg(REG_SITE_GAP, 64'd255);
                end
                2: begin
                    write_reg(REG_SEGMENT_BASE, 64'd0);
                    write_reg(REG_SEGMENT_LENGTH, 64'd0);
                    write_reg(REG_SITE_GAP, 64'd0);
                end
                3: begin
                    write_reg(REG_SEGMENT_BASE, {$urandom, $urandom});
                    write_reg(REG_SEGMENT_LENGTH, {$urandom, 32'($urandom_range(16, 4096))});
                    write_reg(REG_SITE_GAP, {$urandom, $urandom} & ~64'hFF | 64'd1);
                end
                4: begin
                    write_reg(REG_SEGMENT_BASE, 64'hFFFF_FFFF_0000_0000);
                    write_reg(REG_SEGMENT_LENGTH, {$urandom, 32'hFFFF_FFFF});
                    write_reg(REG_SITE_GAP, 64'd3);
                end
                default: begin
                    write_reg(REG_UNMAPPED, {$urandom, $urandom});
                    write_reg(REG_SEGMENT_BASE, 64'h0000_0000_0000_0100);
                    write_reg(REG_SEGMENT_LENGTH, 64'h0000_0000_0000_0020);
                    write_reg(REG_SITE_GAP, {$urandom, $urandom} & ~64'hFF | 64'd2);
                end
            endcase
            // One phase runs with no idling on either side
            steady <= (p == 4);
            run_phase(PHASE_BEATS);
            drain_records();
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/cdsl_pkg.sv
sv/cdsl_regs.sv
sv/cdsl_front.sv
sv/cdsl_queue.sv
sv/cdsl_back.sv
sv/code_diff_site_locator.sv
tb/sv/tb_code_diff_site_locator.sv
